// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) `ASSERT_CHK(label, !(cond), msg)

`endif

// ----- src/ocg_pkg.sv -----
// ----------------------------------------------------------------------------
// ocg_pkg
// shared constants and types of the occupancy change event generator
// ----------------------------------------------------------------------------
package ocg_pkg;

  // defaults for the top level parameters
  localparam int unsigned MODULE_COUNT_DEF = 64;
  localparam int unsigned ID_BASE_DEF      = 100;

  // field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned PIN_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  // low module bits that still reach the sensor address
  localparam int unsigned BASE_W   = ADDR_W - PIN_W;
  localparam int unsigned POS_W    = 4;

  // request from the sequencer to the pin scanner
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] word;
    logic [BASE_W-1:0] base;
  } scan_ctrl_t;

  // scanner status back to the sequencer
  typedef struct packed {
    logic busy;
  } scan_stat_t;

endpackage

// ----- src/ocg_if.sv -----
// ----------------------------------------------------------------------------
// ocg_if
// valid/ready channels for occupancy reports and sensor change events
// ----------------------------------------------------------------------------
interface ocg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] object_id;
  logic [15:0] state_word;

  modport source (output valid, output object_id, output state_word, input ready);
  modport sink   (input valid, input object_id, input state_word, output ready);
endinterface

interface ocg_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] sensor_address;
  logic       occupied;
  logic       last_event;

  modport source (output valid, output sensor_address, output occupied,
                  output last_event, input ready);
  modport sink   (input valid, input sensor_address, input occupied,
                  input last_event, output ready);
endinterface

// ----- src/occupancy_change_event_generator.sv -----
// ----------------------------------------------------------------------------
// occupancy_change_event_generator
// turns occupancy reports into one event per changed sensor pin
// ----------------------------------------------------------------------------
//   channel  dir  payload                                    handshake
//   in_i     in   object_id[15:0] state_word[15:0]           valid/ready
//   out_o    out  sensor_address[9:0] occupied last_event    valid/ready
//
// after reset a clearing pass writes zero to all MODULE_COUNT entries, one a
// cycle, with in_i.ready low until the pass is done
// a report runs through accept, two reads on the single ram read port with
// the two writes overlapped, and a wait state; the scanner walks one pin a
// cycle while out_o takes its events, up to the last changed one of 16 pins
// a stalled out_o holds the pin scanner; in_i.ready stays low until the scan
// of the current report has sent its last event into the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module occupancy_change_event_generator
  import ocg_pkg::*;
#(
  parameter int unsigned MODULE_COUNT = MODULE_COUNT_DEF,
  parameter int unsigned ID_BASE      = ID_BASE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ocg_in_if.sink    in_i,
  ocg_out_if.source out_o
);

  localparam int unsigned AW = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
  localparam int unsigned FW = ID_W + 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MODULE_COUNT - 1);

  // sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD0  = 3'd2;
  localparam logic [2:0] ST_RD1  = 3'd3;
  localparam logic [2:0] ST_RD2  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [FW-1:0]     first_q, first_d;
  logic              v0_q, v0_d, v1_q, v1_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [BYTE_W-1:0] diff0_q, diff0_d;

  logic [ID_W-1:0]   id_off;
  logic [FW-1:0]     first_in;
  logic              id_ok;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]     addr0, addr1;

  scan_ctrl_t        scan_ctrl;
  scan_stat_t        scan_st;

  // first module index of the incoming report
  assign id_off   = in_i.object_id - ID_W'(ID_BASE);
  assign first_in = {id_off, 1'b0};
  assign id_ok    = (in_i.object_id >= ID_W'(ID_BASE));

  // first module is even, so its neighbor just sets bit 0
  assign addr0 = first_q[AW-1:0];
  assign addr1 = first_q[AW-1:0] | AW'(1);

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    first_d   = first_q;
    v0_d      = v0_q;
    v1_d      = v1_q;
    word_d    = word_q;
    diff0_d   = diff0_q;
    ram_we    = 1'b0;
    ram_waddr = addr0;
    ram_wdata = word_q[BYTE_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = addr0;
    scan_ctrl = '0;
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          first_d = first_in;
          word_d  = in_i.state_word;
          v0_d    = id_ok && (first_in < FW'(MODULE_COUNT));
          v1_d    = id_ok && (first_in < FW'(MODULE_COUNT - 1));
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = addr0;
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        // old byte of the first module is back, store the new one
        ram_re    = 1'b1;
        ram_raddr = addr1;
        diff0_d   = v0_q ? (ram_rdata ^ word_q[BYTE_W-1:0]) : '0;
        ram_we    = v0_q;
        ram_waddr = addr0;
        ram_wdata = word_q[BYTE_W-1:0];
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        // second module, then hand both change masks to the scanner
        ram_we         = v1_q;
        ram_waddr      = addr1;
        ram_wdata      = word_q[WORD_W-1:BYTE_W];
        scan_ctrl.load = 1'b1;
        scan_ctrl.diff = {(v1_q ? (ram_rdata ^ word_q[WORD_W-1:BYTE_W]) : BYTE_W'(0)),
                          diff0_q};
        scan_ctrl.word = word_q;
        scan_ctrl.base = first_q[BASE_W-1:0];
        state_d        = ST_WAIT;
      end
      ST_WAIT: begin
        if (!scan_st.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    word_q  <= word_d;
    diff0_q <= diff0_d;
  end

  // last byte of every module
  ocg_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MODULE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pin scanner and output register
  ocg_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .stat_o (scan_st),
    .out_o  (out_o)
  );

  // a new request only once the previous scan is finished
  `ASSERT_CHK(a_ready_idle, in_i.ready |-> !scan_st.busy, "ready while scanning")
  // never read and write the same store entry in one cycle
  `ASSERT_NEVER(a_rw_clash, ram_we && ram_re && (ram_waddr == ram_raddr),
                "store read and write collide")
  // clearing pass runs through the whole store
  `ASSERT_CHK(a_clr_run, (state_q == ST_CLR && clr_q != CLR_LAST) |=> state_q == ST_CLR,
              "clearing pass left early")

endmodule

// ----- src/ocg_ram.sv -----
// ----------------------------------------------------------------------------
// ocg_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ocg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ocg_scan.sv -----
// ----------------------------------------------------------------------------
// ocg_scan
// pin scanner: walks a 16-bit change mask one pin a cycle unless a held event stalls it, emits events
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocg_scan
  import ocg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_ctrl_t ctrl_i,
  output scan_stat_t stat_o,
  ocg_out_if.source  out_o
);

  logic [WORD_W-1:0] mask_q, mask_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              busy;
  logic              slot_free;
  logic [WORD_W-1:0] rest;

  logic              vld_q, vld_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              occ_q, occ_d;
  logic              last_q, last_d;

  assign busy      = (mask_q != '0);
  assign slot_free = !vld_q || out_o.ready;
  // changes still pending once the current pin is sent
  assign rest      = mask_q & ~(WORD_W'(1) << pos_q);

  // scan step and output register
  always_comb begin
    mask_d = mask_q;
    word_d = word_q;
    base_d = base_q;
    pos_d  = pos_q;
    vld_d  = vld_q && !out_o.ready;
    addr_d = addr_q;
    occ_d  = occ_q;
    last_d = last_q;
    if (ctrl_i.load) begin
      mask_d = ctrl_i.diff;
      word_d = ctrl_i.word;
      base_d = ctrl_i.base;
      pos_d  = '0;
    end else if (busy) begin
      if (!mask_q[pos_q]) begin
        pos_d = pos_q + POS_W'(1);
      end else if (slot_free) begin
        vld_d  = 1'b1;
        addr_d = {base_q, {PIN_W{1'b0}}} + ADDR_W'(pos_q) + ADDR_W'(1);
        occ_d  = word_q[pos_q];
        last_d = (rest == '0);
        mask_d = rest;
        pos_d  = pos_q + POS_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      pos_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      pos_q  <= pos_d;
      vld_q  <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    base_q <= base_d;
    addr_q <= addr_d;
    occ_q  <= occ_d;
    last_q <= last_d;
  end

  assign stat_o.busy          = busy;
  assign out_o.valid          = vld_q;
  assign out_o.sensor_address = addr_q;
  assign out_o.occupied       = occ_q;
  assign out_o.last_event     = last_q;

  // a new mask never overwrites pending changes
  `ASSERT_NEVER(a_load_idle, ctrl_i.load && busy, "scan loaded while busy")

endmodule

// ----- tb/tb_occupancy_change_event_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_change_event_generator
// self-checking bench: drives occupancy reports through the request channel,
// predicts the pin change events from a shadow copy of the module store and
// checks every event field by field, with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_occupancy_change_event_generator;
  import ocg_pkg::*;

  localparam int unsigned N_MOD      = MODULE_COUNT_DEF;
  localparam int unsigned ID_LO      = ID_BASE_DEF;
  localparam int unsigned N_RANDOM   = 130;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_WAIT  = 32;

  // one predicted change event
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              occ;
    logic              last;
  } pin_event_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_chk_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] word;
    row_chk_e          chk;
    logic [ADDR_W-1:0] addr;
    logic              occ;
  } stim_row_t;

  // directed reports, walked in order right after reset
  localparam int unsigned N_DIR = 20;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{16'd100,   16'h0001, CHK_ONE,   10'd1,   1'b1},  // first pin after reset
    '{16'd100,   16'h0001, CHK_NONE,  10'd0,   1'b0},  // no change
    '{16'd99,    16'hFFFF, CHK_NONE,  10'd0,   1'b0},  // id just below base
    '{16'd0,     16'hFFFF, CHK_NONE,  10'd0,   1'b0},  // smallest id
    '{16'd132,   16'hFFFF, CHK_NONE,  10'd0,   1'b0},  // both modules past the store
    '{16'd65535, 16'hFFFF, CHK_NONE,  10'd0,   1'b0},  // largest id
    '{16'd32768, 16'h0000, CHK_NONE,  10'd0,   1'b0},
    '{16'd131,   16'h8000, CHK_ONE,   10'd512, 1'b1},  // highest sensor address
    '{16'd131,   16'h7FFF, CHK_MODEL, 10'd0,   1'b0},  // all sixteen pins flip
    '{16'd131,   16'h0000, CHK_MODEL, 10'd0,   1'b0},
    '{16'd100,   16'hFFFF, CHK_MODEL, 10'd0,   1'b0},
    '{16'd100,   16'hFFFE, CHK_ONE,   10'd1,   1'b0},  // lowest pin goes free
    '{16'd100,   16'h0000, CHK_MODEL, 10'd0,   1'b0},
    '{16'd115,   16'hA55A, CHK_MODEL, 10'd0,   1'b0},
    '{16'd115,   16'h5AA5, CHK_MODEL, 10'd0,   1'b0},
    '{16'd115,   16'h5AA5, CHK_NONE,  10'd0,   1'b0},
    '{16'd116,   16'h0100, CHK_ONE,   10'd265, 1'b1},  // high byte only
    '{16'd101,   16'h8000, CHK_ONE,   10'd32,  1'b1},
    '{16'd130,   16'h0080, CHK_MODEL, 10'd0,   1'b0},
    '{16'd99,    16'h0000, CHK_NONE,  10'd0,   1'b0}
  };

  logic clk_i;
  logic rst_ni;

  ocg_in_if  in_if ();
  ocg_out_if out_if ();

  occupancy_change_event_generator #(
    .MODULE_COUNT(N_MOD),
    .ID_BASE     (ID_LO)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // shadow of the module store and the pending events
  logic [BYTE_W-1:0] occ_bytes [N_MOD];
  pin_event_t        pending_events[$];

  int unsigned err_cnt;
  int unsigned event_cnt;
  int unsigned report_cnt;
  int unsigned ignored_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch on event %0d, %s: expected %0d got %0d",
             event_cnt, what, want, got);
    err_cnt++;
  endtask

  // events caused by one report, and the store update that follows it
  function automatic void scan_report(input logic [ID_W-1:0] id,
                                      input logic [WORD_W-1:0] word,
                                      ref pin_event_t evs[$]);
    int unsigned       first;
    int unsigned       mod;
    logic [BYTE_W-1:0] was;
    logic [BYTE_W-1:0] now;
    evs.delete();
    if (id < ID_LO) return;
    first = (int'(id) - ID_LO) * 2;
    for (int k = 0; k < 2; k++) begin
      mod = first + k;
      if (mod < N_MOD) begin
        was = occ_bytes[mod];
        now = word[k*BYTE_W +: BYTE_W];
        for (int pin = 0; pin < BYTE_W; pin++) begin
          if (was[pin] != now[pin])
            evs.push_back('{addr: ADDR_W'(mod * BYTE_W + pin + 1), occ: now[pin],
                            last: 1'b0});
        end
        occ_bytes[mod] = now;
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
  endfunction

  // one request on the input channel, with bursts and gaps between them
  task automatic send_report(input logic [ID_W-1:0] id, input logic [WORD_W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_if.valid      = 1'b1;
    in_if.object_id  = id;
    in_if.state_word = word;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
  endtask

  // send a report and queue what it should produce
  task automatic run_report(input logic [ID_W-1:0] id, input logic [WORD_W-1:0] word,
                            input row_chk_e chk, input logic [ADDR_W-1:0] addr,
                            input logic occ);
    pin_event_t evs[$];
    send_report(id, word);
    scan_report(id, word, evs);
    report_cnt++;
    if (evs.size() == 0) ignored_cnt++;
    case (chk)
      CHK_MODEL: begin
        foreach (evs[i]) pending_events.push_back(evs[i]);
      end
      CHK_ONE: begin
        pending_events.push_back('{addr: addr, occ: occ, last: 1'b1});
      end
      default: ;
    endcase
  endtask

  // receiver stall pattern, switching among four randomly picked modes
  initial begin : out_stall
    int unsigned cyc;
    int unsigned mode;
    int unsigned hold;
    out_if.ready = 1'b0;
    cyc  = 0;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_if.ready = 1'b1;
        1: out_if.ready = 1'($urandom_range(0, 1));
        2: out_if.ready = (cyc % 8) >= 3;
        default: begin
          // long stalls with short open windows
          if (hold == 0) begin
            out_if.ready = ~out_if.ready;
            hold = out_if.ready ? $urandom_range(1, 4) : $urandom_range(5, 25);
          end
          hold--;
        end
      endcase
      cyc++;
    end
  end

  // event checker
  always @(posedge clk_i) begin : chk_events
    pin_event_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("no event pending, sensor address", 0,
                        32'(out_if.sensor_address));
      end else begin
        want = pending_events.pop_front();
        if (out_if.sensor_address !== want.addr)
          report_mismatch("sensor address", 32'(want.addr), 32'(out_if.sensor_address));
        if (out_if.occupied !== want.occ)
          report_mismatch("occupied", 32'(want.occ), 32'(out_if.occupied));
        if (out_if.last_event !== want.last)
          report_mismatch("last event", 32'(want.last), 32'(out_if.last_event));
      end
      event_cnt++;
    end
  end

  // watchdog on cycles without any accepted request or event
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // reset, directed rows, then random reports
  initial begin : stimulus
    int unsigned       sel;
    int unsigned       mod;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] word;
    err_cnt          = 0;
    event_cnt        = 0;
    report_cnt       = 0;
    ignored_cnt      = 0;
    idle_cycles      = 0;
    burst_left       = 0;
    in_if.valid      = 1'b0;
    in_if.object_id  = '0;
    in_if.state_word = '0;
    foreach (occ_bytes[i]) occ_bytes[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < N_DIR; r++)
      run_report(DIR_ROWS[r].id, DIR_ROWS[r].word, DIR_ROWS[r].chk,
                 DIR_ROWS[r].addr, DIR_ROWS[r].occ);

    while (report_cnt < N_DIR + N_RANDOM) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        // noise: any id, mostly outside the store
        id   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, ID_LO - 1));
        word = 16'($urandom_range(0, 65535));
      end else begin
        id  = 16'(ID_LO + $urandom_range(0, N_MOD / 2 - 1));
        mod = (int'(id) - ID_LO) * 2;
        case ($urandom_range(0, 5))
          0: word = {occ_bytes[mod+1], occ_bytes[mod]};
          1: word = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
          2, 3: word = {occ_bytes[mod+1], occ_bytes[mod]}
                       ^ (16'h1 << $urandom_range(0, 15))
                       ^ (16'h1 << $urandom_range(0, 15));
          default: word = 16'($urandom_range(0, 65535));
        endcase
      end
      run_report(id, word, CHK_MODEL, '0, 1'b0);
    end
    @(negedge clk_i);
    in_if.valid = 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("%0d reports sent, %0d gave no events; %0d events checked",
             report_cnt, ignored_cnt, event_cnt);
    $display("%0d mismatches", err_cnt);
    if (err_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ocg_pkg.sv
src/ocg_if.sv
src/ocg_ram.sv
src/ocg_scan.sv
src/occupancy_change_event_generator.sv
tb/tb_occupancy_change_event_generator.sv
